/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wsd_pkg.sv */
// ---------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes of the WebSocket frame deframer.
// ---------------------------------------------------------------------------
package wsd_pkg;

    localparam int LEN_W  = 63;
    localparam int MAX_W  = 31;

    localparam logic [MAX_W-1:0] MAX_FRAME_RESET = 31'h7FFF_FFFF;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error causes
    localparam logic [2:0] CAUSE_NONE       = 3'd0;
    localparam logic [2:0] CAUSE_RSV        = 3'd1;
    localparam logic [2:0] CAUSE_OPCODE     = 3'd2;
    localparam logic [2:0] CAUSE_CTRL_LONG  = 3'd3;
    localparam logic [2:0] CAUSE_CTRL_FRAG  = 3'd4;
    localparam logic [2:0] CAUSE_NONMIN_16  = 3'd5;
    localparam logic [2:0] CAUSE_NONMIN_64  = 3'd6;
    localparam logic [2:0] CAUSE_OVERSIZE   = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       fin;
        logic [3:0] opcode;
        logic [2:0] cause;
        logic       frame_end;
    } result_t;

endpackage

/* hdl/wsd_in_stage.sv */
// ---------------------------------------------------------------------------
// wsd_in_stage
// Input register for stream bytes; holds one byte while the result side waits.
// ---------------------------------------------------------------------------
module wsd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] stream_byte,
    input  logic       out_ready,
    output logic       fire,
    output logic [7:0] byte_q
);
    import wsd_pkg::*;

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign fire       = vld_reg && out_ready;
    assign byte_stall = vld_reg && !out_ready;
    assign accept     = byte_valid && !byte_stall;
    assign byte_q     = byte_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (fire)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= stream_byte;
        end
    end

endmodule

/* hdl/wsd_parser.sv */
// ---------------------------------------------------------------------------
// wsd_parser
// Frame header/length/mask parser and payload unmasking, one byte per fire.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wsd_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [7:0]                byte_in,
    input  logic                      cfg_wr_en,
    input  logic [wsd_pkg::MAX_W-1:0] cfg_wr_data,
    output logic                      res_vld,
    output wsd_pkg::result_t          res
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_LEN16 = 3'd2,
        PH_LEN64 = 3'd3,
        PH_MASK  = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic               fin_reg,    fin_next;
    logic [3:0]         op_reg,     op_next;
    logic               masked_reg, masked_next;
    logic               rsv_reg,    rsv_next;
    logic [LEN_W-1:0]   len_reg,    len_next;
    logic [2:0]         cnt_reg,    cnt_next;
    logic [31:0]        key_reg,    key_next;
    logic [MAX_W-1:0]   max_reg;

    logic [LEN_W-1:0]   len_shift;
    logic [6:0]         code;
    logic               control;
    logic               len_done;
    logic               start_pl;
    logic [LEN_W-1:0]   start_len;

    assign len_shift = {len_reg[LEN_W-9:0], byte_in};
    assign code      = byte_in[6:0];
    assign control   = op_reg[3];

    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        op_next     = op_reg;
        masked_next = masked_reg;
        rsv_next    = rsv_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        len_done    = 1'b0;
        start_pl    = 1'b0;
        start_len   = len_reg;
        res_vld     = 1'b0;
        res         = '0;
        res.fin     = fin_reg;
        res.opcode  = op_reg;

        unique case (phase_reg)
            PH_HDR1:
            begin
                masked_next = byte_in[7];
                cnt_next    = '0;
                if (rsv_reg)
                begin
                    res_vld   = 1'b1;
                    res.kind  = KIND_ERROR;
                    res.cause = CAUSE_RSV;
                end
                else if ((op_reg >= 4'd3 && op_reg <= 4'd7) || op_reg >= 4'd11)
                begin
                    res_vld   = 1'b1;
                    res.kind  = KIND_ERROR;
                    res.cause = CAUSE_OPCODE;
                end
                else if (control && code > 7'd125)
                begin
                    res_vld   = 1'b1;
                    res.kind  = KIND_ERROR;
                    res.cause = CAUSE_CTRL_LONG;
                end
                else if (control && !fin_reg)
                begin
                    res_vld   = 1'b1;
                    res.kind  = KIND_ERROR;
                    res.cause = CAUSE_CTRL_FRAG;
                end
                else if (code == 7'd126)
                begin
                    phase_next = PH_LEN16;
                    len_next   = '0;
                end
                else if (code == 7'd127)
                begin
                    phase_next = PH_LEN64;
                    len_next   = '0;
                end
                else
                begin
                    len_done  = 1'b1;
                    start_len = {{(LEN_W-7){1'b0}}, code};
                end
            end
            PH_LEN16:
            begin
                len_next = len_shift;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd1)
                begin
                    if (len_shift < LEN_W'(126))
                    begin
                        res_vld   = 1'b1;
                        res.kind  = KIND_ERROR;
                        res.cause = CAUSE_NONMIN_16;
                    end
                    else
                    begin
                        len_done  = 1'b1;
                        start_len = len_shift;
                    end
                end
            end
            PH_LEN64:
            begin
                // shifting into 63 bits drops the top bit of the first byte
                len_next = len_shift;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    if (len_shift[LEN_W-1:16] == '0)
                    begin
                        res_vld   = 1'b1;
                        res.kind  = KIND_ERROR;
                        res.cause = CAUSE_NONMIN_64;
                    end
                    else
                    begin
                        len_done  = 1'b1;
                        start_len = len_shift;
                    end
                end
            end
            PH_MASK:
            begin
                key_next = {key_reg[23:0], byte_in};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    start_pl = 1'b1;
                end
            end
            PH_DATA:
            begin
                // key rotates so its top byte always lines up with the next byte
                res_vld       = 1'b1;
                res.kind      = KIND_DATA;
                res.data      = byte_in ^ key_reg[31:24];
                res.frame_end = (len_reg == LEN_W'(1));
                key_next      = {key_reg[23:0], key_reg[31:24]};
                len_next      = len_reg - LEN_W'(1);
                if (res.frame_end)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                fin_next    = byte_in[7];
                rsv_next    = (byte_in[6:4] != 3'd0);
                op_next     = byte_in[3:0];
                masked_next = 1'b0;
                key_next    = '0;
                len_next    = '0;
                cnt_next    = '0;
                phase_next  = PH_HDR1;
            end
        endcase

        if (len_done)
        begin
            len_next = start_len;
            if (masked_next)
            begin
                phase_next = PH_MASK;
                cnt_next   = '0;
            end
            else
            begin
                start_pl = 1'b1;
            end
        end

        if (start_pl)
        begin
            cnt_next = '0;
            if (start_len == '0)
            begin
                res_vld  = 1'b1;
                res.kind = KIND_EMPTY;
            end
            else if (start_len > {{(LEN_W-MAX_W){1'b0}}, max_reg})
            begin
                res_vld   = 1'b1;
                res.kind  = KIND_ERROR;
                res.cause = CAUSE_OVERSIZE;
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end

        // errors and empty frames end here
        if (res_vld && res.kind != KIND_DATA)
        begin
            res.frame_end = 1'b1;
            phase_next    = PH_HDR0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            fin_reg    <= 1'b1;
            op_reg     <= '0;
            masked_reg <= 1'b0;
            rsv_reg    <= 1'b0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            key_reg    <= '0;
            max_reg    <= MAX_FRAME_RESET;
        end
        else
        begin
            if (fire)
            begin
                phase_reg  <= phase_next;
                fin_reg    <= fin_next;
                op_reg     <= op_next;
                masked_reg <= masked_next;
                rsv_reg    <= rsv_next;
                len_reg    <= len_next;
                cnt_reg    <= cnt_next;
                key_reg    <= key_next;
            end
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    `ASSERT_NEXT(a_end_to_hdr0, fire && res_vld && res.frame_end, phase_reg == PH_HDR0,
                 "frame end did not return to header")
    `ASSERT_IMP(a_data_len_live, phase_reg == PH_DATA, len_reg != '0,
                "payload phase with zero remaining")

endmodule

/* hdl/wsd_out_stage.sv */
// ---------------------------------------------------------------------------
// wsd_out_stage
// Result register driving the output channel.
// ---------------------------------------------------------------------------
module wsd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             res_vld,
    input  wsd_pkg::result_t res,
    input  logic             result_stall,
    output logic             result_valid,
    output wsd_pkg::result_t res_q
);
    import wsd_pkg::*;

    logic    vld_reg;
    result_t res_reg;

    assign result_valid = vld_reg;
    assign res_q        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            vld_reg <= res_vld;
        end
        else if (!result_stall)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_vld)
        begin
            res_reg <= res;
        end
    end

endmodule

/* hdl/websocket_frame_deframer_unit.sv */
// Throughput: one byte per cycle while no result waits on result_stall;
// header, length and mask bytes give no data result.
// Pipeline: input register -> parser logic -> result register; the input
// register holds one byte while a result waits on result_stall.
// Reset: rst_n is asynchronous; parser starts at the first header byte and
// max_frame_size returns to 0x7FFFFFFF.
// ---------------------------------------------------------------------------
// websocket_frame_deframer_unit
// WebSocket frame deframer: parses headers, checks them and unmasks payload.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module websocket_frame_deframer_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    // byte input channel
    input  logic                      byte_valid,
    output logic                      byte_stall,
    input  logic [7:0]                stream_byte,
    // max_frame_size register
    input  logic                      cfg_wr_en,
    input  logic [wsd_pkg::MAX_W-1:0] cfg_wr_data,
    // result channel
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [1:0]                kind,
    output logic [7:0]                data_byte,
    output logic                      final_fragment,
    output logic [3:0]                frame_opcode,
    output logic [2:0]                error_cause,
    output logic                      frame_end
);
    import wsd_pkg::*;

    logic       out_ready;
    logic       fire;
    logic [7:0] byte_q;
    logic       res_vld;
    result_t    res;
    result_t    res_q;

    // the parser may advance when the result register is empty or draining
    assign out_ready = !result_valid || !result_stall;

    wsd_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .stream_byte (stream_byte),
        .out_ready   (out_ready),
        .fire        (fire),
        .byte_q      (byte_q)
    );

    // all per-byte work: state update and the one result it may cause
    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .byte_in     (byte_q),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_vld     (res_vld),
        .res         (res)
    );

    wsd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .res_vld      (res_vld),
        .res          (res),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .res_q        (res_q)
    );

    assign kind           = res_q.kind;
    assign data_byte      = res_q.data;
    assign final_fragment = res_q.fin;
    assign frame_opcode   = res_q.opcode;
    assign error_cause    = res_q.cause;
    assign frame_end      = res_q.frame_end;

    // input only backs up behind a blocked result
    `ASSERT_IMP(a_stall_needs_result, byte_stall, result_valid && result_stall,
                "input stalled with result side free")

endmodule

/* tb/websocket_deframe_checker.sv */
// ---------------------------------------------------------------------------
// websocket_deframe_checker
// Watches the byte and result channels of the deframer, parses the byte
// stream on its own and compares every result transfer with the oldest
// predicted one.
// ---------------------------------------------------------------------------
package ws_opcode_pkg;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BIN    = 4'h2;
    localparam logic [3:0] OP_RESV_3 = 4'h3;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;
    localparam logic [3:0] OP_RESV_F = 4'hF;

    // data opcodes 3..7 and control opcodes 11..15 are unassigned
    function automatic bit opcode_reserved(input logic [3:0] op);
        return (op > OP_BIN && op < OP_CLOSE) || op > OP_PONG;
    endfunction

endpackage

module websocket_deframe_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [7:0]  stream_byte,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        final_fragment,
    input  logic [3:0]  frame_opcode,
    input  logic [2:0]  error_cause,
    input  logic        frame_end,
    output int          mismatch_count,
    output int          pending_count
);
    import wsd_pkg::*;
    import ws_opcode_pkg::*;

    typedef enum logic [2:0] {
        WAIT_HEAD0  = 3'd0,
        WAIT_HEAD1  = 3'd1,
        GET_LEN16   = 3'd2,
        GET_LEN64   = 3'd3,
        GET_KEY     = 3'd4,
        GET_PAYLOAD = 3'd5
    } parse_state_t;

    parse_state_t state;
    logic [30:0]  size_limit;
    logic         fin_bit;
    logic         rsv_bit;
    logic         mask_on;
    logic [3:0]   op_held;
    logic [62:0]  frame_len;
    logic [62:0]  field_count;
    logic [31:0]  key;

    result_t predicted_results[$];
    result_t new_res;
    result_t got;
    result_t want;

    function automatic result_t outcome(input logic [1:0] k, input logic [7:0] d,
                                        input logic [2:0] c, input logic e);
        result_t r;
        r.kind      = k;
        r.data      = d;
        r.fin       = fin_bit;
        r.opcode    = op_held;
        r.cause     = c;
        r.frame_end = e;
        return r;
    endfunction

    function automatic result_t abort_frame(input logic [2:0] c);
        state = WAIT_HEAD0;
        return outcome(KIND_ERROR, 8'h00, c, 1'b1);
    endfunction

    // length and key known: empty frame, oversize, or payload follows
    function automatic bit open_payload(output result_t res);
        field_count = '0;
        if (frame_len == '0)
        begin
            state = WAIT_HEAD0;
            res = outcome(KIND_EMPTY, 8'h00, CAUSE_NONE, 1'b1);
            return 1'b1;
        end
        if (frame_len > {32'd0, size_limit})
        begin
            res = abort_frame(CAUSE_OVERSIZE);
            return 1'b1;
        end
        state = GET_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic bit close_length(output result_t res);
        field_count = '0;
        if (mask_on)
        begin
            state = GET_KEY;
            return 1'b0;
        end
        return open_payload(res);
    endfunction

    // one received byte; returns 1 when it yields a result
    function automatic bit parse_byte(input logic [7:0] b, output result_t res);
        logic [6:0] code;
        logic [4:0] shift;
        logic       last;
        case (state)
            WAIT_HEAD1:
            begin
                code    = b[6:0];
                mask_on = b[7];
                if (rsv_bit)
                begin
                    res = abort_frame(CAUSE_RSV);
                    return 1'b1;
                end
                if (opcode_reserved(op_held))
                begin
                    res = abort_frame(CAUSE_OPCODE);
                    return 1'b1;
                end
                if (op_held[3] && code > 7'd125)
                begin
                    res = abort_frame(CAUSE_CTRL_LONG);
                    return 1'b1;
                end
                if (op_held[3] && !fin_bit)
                begin
                    res = abort_frame(CAUSE_CTRL_FRAG);
                    return 1'b1;
                end
                field_count = '0;
                frame_len   = '0;
                if (code == 7'd126)
                begin
                    state = GET_LEN16;
                    return 1'b0;
                end
                if (code == 7'd127)
                begin
                    state = GET_LEN64;
                    return 1'b0;
                end
                frame_len = 63'(code);
                return close_length(res);
            end
            GET_LEN16:
            begin
                frame_len   = ((frame_len << 8) | 63'(b)) & 63'hFFFF;
                field_count = field_count + 63'd1;
                if (field_count < 63'd2)
                    return 1'b0;
                if (frame_len < 63'd126)
                begin
                    res = abort_frame(CAUSE_NONMIN_16);
                    return 1'b1;
                end
                return close_length(res);
            end
            GET_LEN64:
            begin
                // 63-bit store drops the top bit of the wire length
                frame_len   = (frame_len << 8) | 63'(b);
                field_count = field_count + 63'd1;
                if (field_count < 63'd8)
                    return 1'b0;
                if (frame_len <= 63'hFFFF)
                begin
                    res = abort_frame(CAUSE_NONMIN_64);
                    return 1'b1;
                end
                return close_length(res);
            end
            GET_KEY:
            begin
                key         = (key << 8) | 32'(b);
                field_count = field_count + 63'd1;
                if (field_count < 63'd4)
                    return 1'b0;
                return open_payload(res);
            end
            GET_PAYLOAD:
            begin
                shift       = 5'd24 - {field_count[1:0], 3'b000};
                field_count = field_count + 63'd1;
                last        = field_count >= frame_len;
                if (last)
                    state = WAIT_HEAD0;
                res = outcome(KIND_DATA, b ^ 8'(key >> shift), CAUSE_NONE, last);
                return 1'b1;
            end
            default:
            begin
                fin_bit     = b[7];
                rsv_bit     = |b[6:4];
                op_held     = b[3:0];
                mask_on     = 1'b0;
                key         = '0;
                frame_len   = '0;
                field_count = '0;
                state       = WAIT_HEAD1;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state       = WAIT_HEAD0;
            size_limit  = MAX_FRAME_RESET;
            fin_bit     = 1'b1;
            rsv_bit     = 1'b0;
            mask_on     = 1'b0;
            op_held     = '0;
            frame_len   = '0;
            field_count = '0;
            key         = '0;
            predicted_results.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                size_limit = cfg_wr_data;

            if (result_valid && !result_stall)
            begin
                got = '{kind, data_byte, final_fragment, frame_opcode, error_cause,
                        frame_end};
                if (predicted_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: result transfer with nothing predicted: kind %0d data %02h",
                                 $realtime, kind, data_byte);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data
                        || got.fin !== want.fin || got.opcode !== want.opcode
                        || got.cause !== want.cause || got.frame_end !== want.frame_end)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $write("%0t: result mismatch (exp/act) kind %0d/%0d data %02h/%02h",
                                   $realtime, want.kind, got.kind, want.data, got.data);
                            $display(" fin %0d/%0d op %0d/%0d cause %0d/%0d end %0d/%0d",
                                     want.fin, got.fin, want.opcode, got.opcode,
                                     want.cause, got.cause, want.frame_end, got.frame_end);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end

            if (byte_valid && !byte_stall)
            begin
                if (parse_byte(stream_byte, new_res))
                    predicted_results.push_back(new_res);
            end

            pending_count <= predicted_results.size();
        end
    end

endmodule

/* tb/tb_websocket_frame_deframer_unit.sv */
// ---------------------------------------------------------------------------
// tb_websocket_frame_deframer_unit
// Drives whole WebSocket frames, good and broken, through the deframer at
// several max_frame_size settings with random idle and stall cycles; a
// checker beside the block predicts and compares every result transfer.
// ---------------------------------------------------------------------------
module tb_websocket_frame_deframer_unit;

    import wsd_pkg::*;
    import ws_opcode_pkg::*;

    // how the payload length is carried in the header
    typedef enum int {
        LEN_SHORT = 0,
        LEN_EXT16 = 1,
        LEN_EXT64 = 2
    } len_form_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_stall;
    logic [7:0]  stream_byte  = 8'h00;
    logic        cfg_wr_en    = 1'b0;
    logic [30:0] cfg_wr_data  = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        final_fragment;
    logic [3:0]  frame_opcode;
    logic [2:0]  error_cause;
    logic        frame_end;

    int          fault_total;
    int          results_due;

    // stimulus knobs
    bit          send_gaps  = 1'b1;   // random idle cycles on the byte side
    bit          sink_gaps  = 1'b1;   // random stall cycles on the result side
    logic [30:0] limit_now  = MAX_FRAME_RESET;
    int          bytes_sent = 0;

    websocket_frame_deframer_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .stream_byte    (stream_byte),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .data_byte      (data_byte),
        .final_fragment (final_fragment),
        .frame_opcode   (frame_opcode),
        .error_cause    (error_cause),
        .frame_end      (frame_end)
    );

    websocket_deframe_checker deframe_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .stream_byte    (stream_byte),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .data_byte      (data_byte),
        .final_fragment (final_fragment),
        .frame_opcode   (frame_opcode),
        .error_cause    (error_cause),
        .frame_end      (frame_end),
        .mismatch_count (fault_total),
        .pending_count  (results_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: stall about a third of the cycles while enabled
    always @(posedge clk)
        result_stall <= sink_gaps && ($urandom_range(99) < 33);

    // One byte transfer. Optional idle cycles go first, then the byte is
    // held until the block takes it. Valid is left high afterwards so that
    // back-to-back bytes never drop valid within one time step.
    task automatic put_byte(input logic [7:0] b);
        if (send_gaps)
        begin
            while ($urandom_range(99) < 33)
            begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
        end
        byte_valid  <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Register write with the block idle: every predicted result has come
    // back, and header bytes still in the pipeline have had time to pass
    // (those give no result of their own).
    task automatic set_limit(input logic [30:0] v);
        byte_valid <= 1'b0;
        @(posedge clk);
        wait (results_due == 0);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        limit_now    = v;
    endtask

    // Sends one frame built from the given fields. Only the bytes the parser
    // will actually ask for are sent: after a header error, a non-minimal
    // length, an oversize length or an empty frame the next byte is already
    // the next header.
    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic masked, input len_form_t form,
                              input logic [63:0] len);
        logic [6:0]  code;
        logic [62:0] body_len;
        logic [31:0] key;
        code = (form == LEN_EXT16) ? 7'd126 : (form == LEN_EXT64) ? 7'd127 : len[6:0];
        put_byte({fin, rsv, op});
        put_byte({masked, code});
        if (rsv != 3'b000 || opcode_reserved(op) || (op[3] && (code > 7'd125 || !fin)))
            return;
        body_len = 63'(code);
        if (form == LEN_EXT16)
        begin
            put_byte(len[15:8]);
            put_byte(len[7:0]);
            body_len = 63'(len[15:0]);
            if (body_len < 63'd126)
                return;
        end
        else if (form == LEN_EXT64)
        begin
            for (int i = 7; i >= 0; i--)
                put_byte(len[8*i +: 8]);
            body_len = len[62:0];
            if (body_len <= 63'hFFFF)
                return;
        end
        if (masked)
        begin
            key = $urandom;
            for (int i = 3; i >= 0; i--)
                put_byte(key[8*i +: 8]);
        end
        if (body_len == '0 || body_len > {32'd0, limit_now})
            return;
        repeat (int'(body_len)) put_byte(8'($urandom_range(255)));
    endtask

    function automatic logic [3:0] pick_opcode();
        case ($urandom_range(5))
            0: return OP_CONT;
            1: return OP_TEXT;
            2: return OP_BIN;
            3: return OP_CLOSE;
            4: return OP_PING;
            default: return OP_PONG;
        endcase
    endfunction

    // Mostly well-formed frames with random content; the rest are frames
    // with random header fields and a little raw noise that can leave the
    // parser out of step until an error brings it back to a header.
    task automatic random_frame();
        int          pick;
        int          r;
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  op;
        logic        masked;
        len_form_t   form;
        logic [63:0] len;
        pick   = $urandom_range(99);
        masked = 1'($urandom_range(1));
        if (pick < 3)
        begin
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)));
            return;
        end
        if (pick < 75)
        begin
            op  = pick_opcode();
            fin = op[3] ? 1'b1 : 1'($urandom_range(1));
            rsv = 3'b000;
            r   = $urandom_range(99);
            if (op[3] || r < 85)
            begin
                form = LEN_SHORT;
                len  = (r < 8) ? 64'd0 : (r < 12) ? 64'($urandom_range(13, 125))
                                                  : 64'($urandom_range(1, 12));
            end
            else if (r < 95)
            begin
                form = LEN_EXT16;
                len  = 64'($urandom_range(126, 160));
            end
            else
            begin
                // always oversize: some bit at or above 2^32 is set
                form = LEN_EXT64;
                len  = {$urandom, $urandom};
                len[32 + $urandom_range(30)] = 1'b1;
            end
        end
        else
        begin
            fin  = 1'($urandom_range(1));
            rsv  = ($urandom_range(3) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
            op   = $urandom_range(1) ? 4'($urandom_range(15)) : pick_opcode();
            form = len_form_t'($urandom_range(2));
            case (form)
                LEN_SHORT: len = 64'($urandom_range(125));
                LEN_EXT16: len = $urandom_range(1) ? 64'($urandom_range(125))
                                                   : 64'($urandom_range(65535));
                default:   len = $urandom_range(1) ? {1'($urandom_range(1)), 47'd0,
                                                      16'($urandom)}
                                                   : {$urandom, $urandom};
            endcase
            // keep accepted payloads short
            if (form == LEN_EXT16 && len[15:0] > 16'd200 && {15'd0, len[15:0]} <= limit_now)
                len[15:0] = 16'd126 + {10'd0, len[5:0]};
            if (form == LEN_EXT64 && len[62:0] > 63'hFFFF && len[62:0] <= {32'd0, limit_now})
                len[40] = 1'b1;
        end
        send_frame(fin, rsv, op, masked, form, len);
    endtask

    task automatic random_stream(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            random_frame();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: each header check, empty frame, masked control payload
        set_limit(MAX_FRAME_RESET);
        send_frame(1'b1, 3'b111, OP_TEXT, 1'b0, LEN_SHORT, 64'd0);      // rsv set
        send_frame(1'b1, 3'b000, OP_RESV_F, 1'b1, LEN_SHORT, 64'd0);    // reserved opcode
        send_frame(1'b1, 3'b000, OP_PING, 1'b0, LEN_EXT16, 64'd200);    // control too long
        send_frame(1'b0, 3'b000, OP_CLOSE, 1'b0, LEN_SHORT, 64'd0);     // control fragmented
        send_frame(1'b1, 3'b000, OP_BIN, 1'b0, LEN_EXT16, 64'd125);     // 16-bit not minimal
        // 64-bit not minimal: the top bit is dropped before the check
        send_frame(1'b0, 3'b000, OP_CONT, 1'b1, LEN_EXT64, 64'h8000_0000_0000_FFFF);
        send_frame(1'b1, 3'b000, OP_CONT, 1'b0, LEN_SHORT, 64'd0);      // empty frame
        send_frame(1'b1, 3'b000, OP_PONG, 1'b1, LEN_SHORT, 64'd1);      // masked payload

        // smallest limit; after the oversize frame, no idle or stall at all
        set_limit(31'd1);
        send_frame(1'b1, 3'b000, OP_TEXT, 1'b1, LEN_SHORT, 64'd2);      // oversize
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        random_stream(300);

        // limit around the payload sizes in use
        set_limit(31'($urandom_range(2, 300)));
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        random_stream(400);

        set_limit(31'($urandom_range(32'h0001_0000, 32'h7FFF_FFFE)));
        sink_gaps = 1'b0;
        random_stream(300);

        // largest limit
        set_limit(MAX_FRAME_RESET);
        sink_gaps = 1'b1;
        random_stream(350);

        // drain: wait until all results are back, then let the pipeline settle
        byte_valid <= 1'b0;
        @(posedge clk);
        wait (results_due == 0);
        repeat (8) @(posedge clk);
        if (fault_total == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
